@@ sv/rqh_pkg.sv @@
package rqh_pkg;

  localparam int CoordWidthDefault = 32;
  localparam int NumCfgRegs = 6;
  localparam int CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_TARGET_X = 3'd3,
    REG_TARGET_Y = 3'd4,
    REG_TARGET_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

endpackage

@@ sv/rqh_tri_pipe.sv @@
module rqh_tri_pipe
  import rqh_pkg::*;
#(
  parameter int CW = CoordWidthDefault
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [CW-1:0] ax, ay, az,
  input  logic signed [CW-1:0] bx, by, bz,
  input  logic signed [CW-1:0] cx, cy, cz,
  input  logic signed [CW-1:0] ox, oy, oz,
  input  logic signed [CW+1:0] dx, dy, dz,
  output logic                 hit
);

  localparam int EW = CW + 2;
  localparam int PW = 2 * EW + 1;
  localparam int SW = 3 * EW + 4;
  localparam int CL = (PW + 2) / 3;
  localparam int HW = PW - 2 * CL;
  localparam int QW = CL + 1 + EW;

  // stage 1: edge and offset vectors
  logic signed [EW-1:0] e0x_r, e0y_r, e0z_r, e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [EW-1:0] pax_r, pay_r, paz_r, pbx_r, pby_r, pbz_r, pcx_r, pcy_r, pcz_r;
  logic signed [EW-1:0] u0x_r, u0y_r, u0z_r, w0x_r, w0y_r, w0z_r;
  logic signed [EW-1:0] dx1_r, dy1_r, dz1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e0x_r <= EW'(bx) - EW'(ax); e0y_r <= EW'(by) - EW'(ay); e0z_r <= EW'(bz) - EW'(az);
      e1x_r <= EW'(cx) - EW'(bx); e1y_r <= EW'(cy) - EW'(by); e1z_r <= EW'(cz) - EW'(bz);
      e2x_r <= EW'(ax) - EW'(cx); e2y_r <= EW'(ay) - EW'(cy); e2z_r <= EW'(az) - EW'(cz);
      pax_r <= EW'(ox) - EW'(ax); pay_r <= EW'(oy) - EW'(ay); paz_r <= EW'(oz) - EW'(az);
      pbx_r <= EW'(ox) - EW'(bx); pby_r <= EW'(oy) - EW'(by); pbz_r <= EW'(oz) - EW'(bz);
      pcx_r <= EW'(ox) - EW'(cx); pcy_r <= EW'(oy) - EW'(cy); pcz_r <= EW'(oz) - EW'(cz);
      u0x_r <= EW'(ax) - EW'(bx); u0y_r <= EW'(ay) - EW'(by); u0z_r <= EW'(az) - EW'(bz);
      w0x_r <= EW'(cx) - EW'(bx); w0y_r <= EW'(cy) - EW'(by); w0z_r <= EW'(cz) - EW'(bz);
      dx1_r <= dx; dy1_r <= dy; dz1_r <= dz;
    end
  end

  // stage 2: cross products (pairs of products, registered)
  logic signed [PW-1:0] c_r [4][3];
  logic signed [EW-1:0] dx2_r, dy2_r, dz2_r;

  function automatic logic signed [PW-1:0] xp(input logic signed [EW-1:0] a1,
      input logic signed [EW-1:0] b2, input logic signed [EW-1:0] a2,
      input logic signed [EW-1:0] b1);
    logic signed [PW-1:0] m1, m2;
    m1 = PW'(a1) * PW'(b2);
    m2 = PW'(a2) * PW'(b1);
    return m1 - m2;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0][0] <= xp(u0y_r, w0z_r, u0z_r, w0y_r);
      c_r[0][1] <= xp(u0z_r, w0x_r, u0x_r, w0z_r);
      c_r[0][2] <= xp(u0x_r, w0y_r, u0y_r, w0x_r);
      c_r[1][0] <= xp(e0y_r, paz_r, e0z_r, pay_r);
      c_r[1][1] <= xp(e0z_r, pax_r, e0x_r, paz_r);
      c_r[1][2] <= xp(e0x_r, pay_r, e0y_r, pax_r);
      c_r[2][0] <= xp(e1y_r, pbz_r, e1z_r, pby_r);
      c_r[2][1] <= xp(e1z_r, pbx_r, e1x_r, pbz_r);
      c_r[2][2] <= xp(e1x_r, pby_r, e1y_r, pbx_r);
      c_r[3][0] <= xp(e2y_r, pcz_r, e2z_r, pcy_r);
      c_r[3][1] <= xp(e2z_r, pcx_r, e2x_r, pcz_r);
      c_r[3][2] <= xp(e2x_r, pcy_r, e2y_r, pcx_r);
      dx2_r <= dx1_r; dy2_r <= dy1_r; dz2_r <= dz1_r;
    end
  end

  // stage 3: dot product terms, each split into three partial products
  logic signed [EW-1:0] d2 [3];
  logic signed [QW-1:0] q_r [4][3][3];

  assign d2[0] = dx2_r;
  assign d2[1] = dy2_r;
  assign d2[2] = dz2_r;

  function automatic logic signed [QW-1:0] lo_mul(input logic [CL-1:0] a,
      input logic signed [EW-1:0] b);
    return QW'($signed({1'b0, a})) * QW'(b);
  endfunction

  function automatic logic signed [QW-1:0] hi_mul(input logic signed [HW-1:0] a,
      input logic signed [EW-1:0] b);
    return QW'(a) * QW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          q_r[k][j][0] <= lo_mul(c_r[k][j][CL-1:0], d2[j]);
          q_r[k][j][1] <= lo_mul(c_r[k][j][2*CL-1:CL], d2[j]);
          q_r[k][j][2] <= hi_mul(c_r[k][j][PW-1:2*CL], d2[j]);
        end
      end
    end
  end

  // stage 4: merge partial products
  logic signed [SW-1:0] t_r [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          t_r[k][j] <= (SW'(q_r[k][j][2]) <<< (2 * CL)) + (SW'(q_r[k][j][1]) <<< CL)
                       + SW'(q_r[k][j][0]);
        end
      end
    end
  end

  // stage 5: sums to signs
  sgn_t s_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s_r[k].neg <= (t_r[k][0] + t_r[k][1] + t_r[k][2]) < 0;
        s_r[k].pos <= (t_r[k][0] + t_r[k][1] + t_r[k][2]) > 0;
      end
    end
  end

  logic any_pos, any_neg;
  assign any_pos = s_r[1].pos | s_r[2].pos | s_r[3].pos;
  assign any_neg = s_r[1].neg | s_r[2].neg | s_r[3].neg;
  assign hit = (s_r[0].pos | s_r[0].neg) & ~(any_pos & any_neg);

endmodule

@@ sv/ray_quad_hit_test_core.sv @@
// Ray / quad hit test core.
// The ray runs from the origin registers through the target registers,
// written over the APB-style cfg_ port (six 32-bit registers at 4*i).
// Each input item is one quad (v0..v3, signed Q16.16); each yields one
// result item: hit flags for triangles v0 v1 v2 and v2 v3 v0, and their OR.
// Input and output use valid/ready. One item per cycle is accepted while
// the pipeline moves. The pipeline has six register stages
// (five arithmetic stages: subtract, cross multiply, partial dot multiply,
// partial merge, sum and sign, then an output register).
// A stall on out_ready freezes the whole pipeline; in_ready then follows
// out_ready, and no item is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the reset
// ray: origin (0, 0, 3.0), target at the origin of space.
// Write registers only while no item is in flight.
module ray_quad_hit_test_core
  import rqh_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [CfgAddrWidth-1:0]       cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_v0_x, in_v0_y, in_v0_z,
  input  logic signed [COORD_WIDTH-1:0] in_v1_x, in_v1_y, in_v1_z,
  input  logic signed [COORD_WIDTH-1:0] in_v2_x, in_v2_y, in_v2_z,
  input  logic signed [COORD_WIDTH-1:0] in_v3_x, in_v3_y, in_v3_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_quad_hit,
  output logic                          out_first_tri_hit,
  output logic                          out_second_tri_hit
);

  localparam int CW = COORD_WIDTH;
  localparam int NSTG = 6;

  logic signed [CW-1:0] reg_r [NumCfgRegs];
  logic [2:0] widx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign widx = cfg_paddr[4:2];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumCfgRegs; i++) begin
        reg_r[i] <= (i == int'(REG_ORIGIN_Z)) ? CW'(196608) : '0;
      end
    end else if (wr_en && widx < 3'(NumCfgRegs)) begin
      reg_r[widx] <= CW'(cfg_pwdata);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00 && widx < 3'(NumCfgRegs)) cfg_prdata = 32'(reg_r[widx]);
  end

  logic signed [CW+1:0] dx, dy, dz;
  assign dx = (CW+2)'(reg_r[REG_TARGET_X]) - (CW+2)'(reg_r[REG_ORIGIN_X]);
  assign dy = (CW+2)'(reg_r[REG_TARGET_Y]) - (CW+2)'(reg_r[REG_ORIGIN_Y]);
  assign dz = (CW+2)'(reg_r[REG_TARGET_Z]) - (CW+2)'(reg_r[REG_ORIGIN_Z]);

  logic adv;
  logic [NSTG-1:0] vld_r;
  logic h1, h2;

  assign adv = out_ready | ~out_valid;
  assign in_ready = adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTG-2:0], in_valid};
  end

  rqh_tri_pipe #(.CW(CW)) u_tri0 (
    .clk(clk), .adv(adv),
    .ax(in_v0_x), .ay(in_v0_y), .az(in_v0_z),
    .bx(in_v1_x), .by(in_v1_y), .bz(in_v1_z),
    .cx(in_v2_x), .cy(in_v2_y), .cz(in_v2_z),
    .ox(reg_r[REG_ORIGIN_X]), .oy(reg_r[REG_ORIGIN_Y]), .oz(reg_r[REG_ORIGIN_Z]),
    .dx(dx), .dy(dy), .dz(dz), .hit(h1)
  );

  rqh_tri_pipe #(.CW(CW)) u_tri1 (
    .clk(clk), .adv(adv),
    .ax(in_v2_x), .ay(in_v2_y), .az(in_v2_z),
    .bx(in_v3_x), .by(in_v3_y), .bz(in_v3_z),
    .cx(in_v0_x), .cy(in_v0_y), .cz(in_v0_z),
    .ox(reg_r[REG_ORIGIN_X]), .oy(reg_r[REG_ORIGIN_Y]), .oz(reg_r[REG_ORIGIN_Z]),
    .dx(dx), .dy(dy), .dz(dz), .hit(h2)
  );

  logic h1_r, h2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      h1_r <= h1;
      h2_r <= h2;
    end
  end

  assign out_first_tri_hit  = h1_r;
  assign out_second_tri_hit = h2_r;
  assign out_quad_hit       = h1_r | h2_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(h1_r) && $stable(h2_r))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready wrong");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item dropped");

endmodule

@@ sim/ray_quad_hit_test_core_test.sv @@
`timescale 1ns / 100ps

module ray_quad_hit_test_core_test;
  import rqh_pkg::*;

  localparam int CW = CoordWidthDefault;
  localparam int ONE = 65536;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t quad_t [12];
  typedef logic signed [127:0] acc_t;
  typedef struct {
    acc_t x, y, z;
  } vec_t;

  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CfgAddrWidth-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  logic in_valid, in_ready;
  coord_t in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z;
  coord_t in_v2_x, in_v2_y, in_v2_z, in_v3_x, in_v3_y, in_v3_z;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_quad_hit, out_first_tri_hit, out_second_tri_hit;

  coord_t ray_regs [6];
  logic [2:0] hits_pending [$];
  int errors = 0;
  int quads_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int ray_settings = 0;
  bit idle_en = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  ray_quad_hit_test_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vec_t mk_vec(coord_t x, coord_t y, coord_t z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic acc_t vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic acc_t edge_det(vec_t p, vec_t q, vec_t o, vec_t d);
    return vdot(vcross(vsub(q, p), vsub(o, p)), d);
  endfunction

  function automatic logic triangle_hit(vec_t a, vec_t b, vec_t c, vec_t o, vec_t d);
    acc_t s [3];
    bit pos, neg;
    if (vdot(d, vcross(vsub(a, b), vsub(c, b))) == 0) return 1'b0;
    s[0] = edge_det(a, b, o, d);
    s[1] = edge_det(b, c, o, d);
    s[2] = edge_det(c, a, o, d);
    pos = 0;
    neg = 0;
    foreach (s[i]) begin
      if (s[i] > 0) pos = 1;
      if (s[i] < 0) neg = 1;
    end
    return !(pos && neg);
  endfunction

  // {quad, first, second}
  function automatic logic [2:0] quad_hits(quad_t q);
    vec_t v [4];
    vec_t o, d;
    logic h1, h2;
    for (int k = 0; k < 4; k++) v[k] = mk_vec(q[3*k], q[3*k+1], q[3*k+2]);
    o = mk_vec(ray_regs[REG_ORIGIN_X], ray_regs[REG_ORIGIN_Y], ray_regs[REG_ORIGIN_Z]);
    d = vsub(mk_vec(ray_regs[REG_TARGET_X], ray_regs[REG_TARGET_Y], ray_regs[REG_TARGET_Z]), o);
    h1 = triangle_hit(v[0], v[1], v[2], o, d);
    h2 = triangle_hit(v[2], v[3], v[0], o, d);
    return {h1 | h2, h1, h2};
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [2:0] want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (out_quad_hit === 1'b1) hits_seen++;
      if (hits_pending.size() == 0) begin
        report_mismatch("result item with nothing pending");
      end else begin
        want = hits_pending.pop_front();
        if (out_quad_hit !== want[2])
          report_mismatch($sformatf("quad_hit %b want %b", out_quad_hit, want[2]));
        if (out_first_tri_hit !== want[1])
          report_mismatch($sformatf("first_tri_hit %b want %b", out_first_tri_hit, want[1]));
        if (out_second_tri_hit !== want[0])
          report_mismatch($sformatf("second_tri_hit %b want %b", out_second_tri_hit,
                                    want[0]));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("ray_quad_hit_test_core_test: done, errors");
      $finish;
    end
  end

  task automatic send_quad(quad_t q);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_v0_x, in_v0_y, in_v0_z} <= {q[0], q[1], q[2]};
    {in_v1_x, in_v1_y, in_v1_z} <= {q[3], q[4], q[5]};
    {in_v2_x, in_v2_y, in_v2_z} <= {q[6], q[7], q[8]};
    {in_v3_x, in_v3_y, in_v3_z} <= {q[9], q[10], q[11]};
    do @(posedge clk); while (!in_ready);
    hits_pending.insert(hits_pending.size(), quad_hits(q));
    quads_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int idx, coord_t val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CfgAddrWidth'(idx * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx < NumCfgRegs) ray_regs[idx] = val;
  endtask

  task automatic set_ray(coord_t ox, oy, oz, tx, ty, tz);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_TARGET_Z, tz);
    ray_settings++;
  endtask

  function automatic quad_t square_xy(coord_t cx, cy, z, h);
    quad_t q;
    q = '{cx - h, cy - h, z, cx + h, cy - h, z, cx + h, cy + h, z, cx - h, cy + h, z};
    return q;
  endfunction

  function automatic coord_t jitter(coord_t c, int r);
    return c + $signed($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic quad_t random_quad();
    quad_t q;
    coord_t c [3];
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      foreach (q[i]) q[i] = $urandom;
    end else if (k == 1) begin
      foreach (q[i]) q[i] = $urandom_range(0, 1) ? CMAX : CMIN;
    end else begin
      // quad around the target point
      for (int i = 0; i < 3; i++) c[i] = jitter(ray_regs[REG_TARGET_X + i], ONE);
      foreach (q[i]) q[i] = jitter(c[i % 3], 2 * ONE);
    end
    return q;
  endfunction

  task automatic test_reset_ray;
    quad_t q;
    send_quad(square_xy(0, 0, 0, ONE));
    send_quad(square_xy(0, 0, -5 * ONE, ONE / 2));
    send_quad(square_xy(4 * ONE, 0, 0, ONE));
    send_quad(square_xy(ONE, ONE, 0, ONE));
    send_quad(square_xy(0, ONE, ONE, ONE));
    send_quad(square_xy(0, 0, 10 * ONE, ONE));
    send_quad(square_xy(0, 0, 3 * ONE, ONE));
    q = '{0, 0, 0, ONE, 0, 0, ONE, 0, ONE, 0, 0, ONE};
    send_quad(q);
    q = '{ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0};
    send_quad(q);
    q = '{0, 0, 0, ONE, ONE, 0, 2 * ONE, 2 * ONE, 0, -ONE, ONE, 0};
    send_quad(q);
    foreach (q[i]) q[i] = CMAX;
    send_quad(q);
    foreach (q[i]) q[i] = CMIN;
    send_quad(q);
    q = '{CMIN, CMIN, 0, CMAX, CMIN, 0, CMAX, CMAX, 0, CMIN, CMAX, CMIN};
    send_quad(q);
    q = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX};
    send_quad(q);
  endtask

  task automatic test_special_rays;
    set_ray(ONE, ONE, ONE, ONE, ONE, ONE);
    send_quad(square_xy(ONE, ONE, 0, ONE));
    set_ray(0, 0, 0, ONE, 0, 0);
    send_quad(square_xy(0, 0, 0, ONE));
    send_quad('{-ONE, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, ONE, ONE, -ONE, -ONE, ONE});
    set_ray(0, 0, 0, 0, 0, ONE);
    send_quad(square_xy(0, 0, 0, ONE));
    send_quad(square_xy(0, 0, -ONE, ONE));
    drain();
    write_reg(NumCfgRegs, ONE);
    write_reg(NumCfgRegs + 1, -ONE);
    send_quad(square_xy(0, 0, ONE, ONE));
    set_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_quad(square_xy(0, 0, 0, ONE));
    send_quad('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX});
    set_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_quad(square_xy(-1, -1, -1, 3));
  endtask

  task automatic test_random_sweep(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) begin
        set_ray(CMIN, 0, CMAX, CMAX, -1, CMIN);
      end else begin
        set_ray(jitter(0, 4 * ONE), jitter(0, 4 * ONE), jitter(0, 4 * ONE),
                jitter(0, 4 * ONE), jitter(0, 4 * ONE), jitter(0, 4 * ONE));
      end
      for (int n = 0; n < per_phase; n++) begin
        if (n == per_phase / 2) begin
          in_valid <= 1'b0;
          while (hits_pending.size() != 0) @(posedge clk);
        end
        send_quad(random_quad());
      end
    end
  endtask

  initial begin
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_valid = 0;
    {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z} = '0;
    {in_v2_x, in_v2_y, in_v2_z, in_v3_x, in_v3_y, in_v3_z} = '0;
    ray_regs = '{0, 0, 3 * ONE, 0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;
    test_reset_ray();
    test_special_rays();
    test_random_sweep(7, 210);
    idle_en = 1'b0;
    test_random_sweep(1, 200);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d quads under %0d ray settings, %0d results, %0d hits",
             quads_sent, ray_settings, results_seen, hits_seen);
    $display("directed edge, parallel, degenerate, zero-ray and extreme cases included");
    if (hits_pending.size() != 0) report_mismatch("results still pending at end");
    if (errors == 0) begin
      $display("ray_quad_hit_test_core_test: done, clean");
    end else begin
      $display("ray_quad_hit_test_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rqh_pkg.sv
sv/rqh_tri_pipe.sv
sv/ray_quad_hit_test_core.sv
sim/ray_quad_hit_test_core_test.sv
